>>> rtl/imm_pkg.sv
// Shared constants and types for the integer matrix multiply block.
// Used by every module under rtl/; depends on nothing else.
`default_nettype none
package imm_pkg;

  localparam int MAX_DIM_DEF    = 8;
  localparam int ELEM_WIDTH_DEF = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

  // classification of one queued word
  typedef struct packed {
    logic is_b;   // word belongs to the second matrix
    logic last;   // final word of the second matrix, start the product
  } imm_tag_t;

  // queue status seen by the top level
  typedef struct packed {
    logic empty;
    logic full;
  } imm_q_stat_t;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_CALC = 2'b10
  } imm_back_st_t;

endpackage
`default_nettype wire

>>> rtl/imm_front.sv
// Front end: classifies each accepted word into first or second matrix and
// gives it its store address. Depends on imm_pkg.
`default_nettype none
module imm_front #(
  parameter int AW      = 6,
  parameter int DW      = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 accept,
  input  wire logic [DW-1:0]        rows_eff,
  input  wire logic [DW-1:0]        inner_eff,
  input  wire logic [DW-1:0]        cols_eff,
  output imm_pkg::imm_tag_t         tag,
  output logic      [AW-1:0]        addr
);

  localparam int CW = AW + 1 + 2 * DW;

  logic [AW-1:0] count_r, count_nxt;
  logic          phase_r, phase_nxt;
  logic [CW-1:0] size_a, size_b, cnt_inc;
  logic          done;

  always_comb begin
    size_a  = CW'(rows_eff) * CW'(inner_eff);
    size_b  = CW'(inner_eff) * CW'(cols_eff);
    cnt_inc = CW'(count_r) + CW'(1);
    done    = cnt_inc >= (phase_r ? size_b : size_a);

    tag.is_b = phase_r;
    tag.last = phase_r & done;
    addr     = count_r;

    count_nxt = count_r;
    phase_nxt = phase_r;
    if (accept) begin
      if (done) begin
        count_nxt = '0;
        phase_nxt = ~phase_r;
      end else begin
        count_nxt = AW'(cnt_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      phase_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/imm_fifo.sv
// Two-entry queue between front end and back end.
// Depends on imm_pkg for its status struct.
`default_nettype none
module imm_fifo #(
  parameter int W = 40
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          pop,
  output logic      [W-1:0]  rdata,
  output imm_pkg::imm_q_stat_t stat
);

  logic [W-1:0] q_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         do_push, do_pop;

  always_comb begin
    do_push    = push && (cnt_r != 2'd2);
    do_pop     = pop && (cnt_r != 2'd0);
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
    rdata      = q_r[rd_ptr_r];
    stat.empty = (cnt_r == 2'd0);
    stat.full  = (cnt_r == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/imm_back.sv
// Back end: matrix stores plus the multiply-accumulate sequencer that walks
// rows, columns and the inner index. Depends on imm_pkg.
`default_nettype none
module imm_back #(
  parameter int MAX_DIM    = imm_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = imm_pkg::ELEM_WIDTH_DEF,
  parameter int AW         = 6,
  parameter int IW         = 3,
  parameter int DW         = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_empty,
  input  wire imm_pkg::imm_tag_t            q_tag,
  input  wire logic [AW-1:0]                q_addr,
  input  wire logic [ELEM_WIDTH-1:0]        q_value,
  output logic                              pop,
  input  wire logic [DW-1:0]                rows_eff,
  input  wire logic [DW-1:0]                inner_eff,
  input  wire logic [DW-1:0]                cols_eff,
  output logic                              res_valid,
  output logic signed [ELEM_WIDTH-1:0]      res_value,
  output logic [IW-1:0]                     res_row,
  output logic [IW-1:0]                     res_col,
  output logic                              res_last
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;

  typedef struct packed {
    logic          first;
    logic          lastk;
    logic [IW-1:0] row;
    logic [IW-1:0] col;
    logic          lastres;
  } mac_tag_t;

  logic [ELEM_WIDTH-1:0] mem_a_r [DEPTH];
  logic [ELEM_WIDTH-1:0] mem_b_r [DEPTH];

  imm_pkg::imm_back_st_t st_r, st_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [AW-1:0] a_addr_r, a_addr_nxt, a_base_r, a_base_nxt, b_addr_r, b_addr_nxt;
  logic          issue, k_end, j_end, i_end;
  mac_tag_t      issue_tag, s1_tag_r, s2_tag_r;
  logic          s1_v_r, s2_v_r;
  logic [ELEM_WIDTH-1:0] rd_a_r, rd_b_r, prod_r, acc_r, acc_sum;
  logic          out_v_r;
  logic [ELEM_WIDTH-1:0] out_val_r;
  logic [IW-1:0] out_row_r, out_col_r;
  logic          out_last_r;

  always_comb begin
    pop   = (st_r == imm_pkg::ST_LOAD) && !q_empty;
    issue = (st_r == imm_pkg::ST_CALC);
    k_end = (DW'(k_r) + DW'(1)) == inner_eff;
    j_end = (DW'(j_r) + DW'(1)) == cols_eff;
    i_end = (DW'(i_r) + DW'(1)) == rows_eff;

    issue_tag.first   = (k_r == '0);
    issue_tag.lastk   = k_end;
    issue_tag.row     = i_r;
    issue_tag.col     = j_r;
    issue_tag.lastres = i_end && j_end;

    st_nxt     = st_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    a_addr_nxt = a_addr_r;
    a_base_nxt = a_base_r;
    b_addr_nxt = b_addr_r;

    case (st_r)
      imm_pkg::ST_LOAD: begin
        if (pop && q_tag.last) begin
          st_nxt     = imm_pkg::ST_CALC;
          i_nxt      = '0;
          j_nxt      = '0;
          k_nxt      = '0;
          a_addr_nxt = '0;
          a_base_nxt = '0;
          b_addr_nxt = '0;
        end
      end
      imm_pkg::ST_CALC: begin
        if (!k_end) begin
          // step the inner index
          k_nxt      = k_r + IW'(1);
          a_addr_nxt = a_addr_r + AW'(1);
          b_addr_nxt = b_addr_r + AW'(cols_eff);
        end else begin
          k_nxt = '0;
          if (!j_end) begin
            j_nxt      = j_r + IW'(1);
            a_addr_nxt = a_base_r;
            b_addr_nxt = AW'(j_r) + AW'(1);
          end else begin
            j_nxt = '0;
            if (!i_end) begin
              i_nxt      = i_r + IW'(1);
              a_base_nxt = a_base_r + AW'(inner_eff);
              a_addr_nxt = a_base_r + AW'(inner_eff);
              b_addr_nxt = '0;
            end else begin
              st_nxt = imm_pkg::ST_LOAD;
            end
          end
        end
      end
      default: st_nxt = imm_pkg::ST_LOAD;
    endcase

    acc_sum = (s2_tag_r.first ? '0 : acc_r) + prod_r;
  end

  // store writes
  always_ff @(posedge clk) begin
    if (pop && q_tag.is_b) begin
      mem_b_r[q_addr] <= q_value;
    end
    if (pop && !q_tag.is_b) begin
      mem_a_r[q_addr] <= q_value;
    end
  end

  // registered store reads, multiply, accumulate
  always_ff @(posedge clk) begin
    rd_a_r   <= mem_a_r[a_addr_r];
    rd_b_r   <= mem_b_r[b_addr_r];
    s1_tag_r <= issue_tag;
    prod_r   <= rd_a_r * rd_b_r;
    s2_tag_r <= s1_tag_r;
    if (s2_v_r) begin
      acc_r <= acc_sum;
    end
    out_val_r  <= acc_sum;
    out_row_r  <= s2_tag_r.row;
    out_col_r  <= s2_tag_r.col;
    out_last_r <= s2_tag_r.lastres;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= imm_pkg::ST_LOAD;
      i_r      <= '0;
      j_r      <= '0;
      k_r      <= '0;
      a_addr_r <= '0;
      a_base_r <= '0;
      b_addr_r <= '0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
      k_r      <= k_nxt;
      a_addr_r <= a_addr_nxt;
      a_base_r <= a_base_nxt;
      b_addr_r <= b_addr_nxt;
      s1_v_r   <= issue;
      s2_v_r   <= s1_v_r;
      out_v_r  <= s2_v_r && s2_tag_r.lastk;
    end
  end

  assign res_valid = out_v_r;
  assign res_value = out_val_r;
  assign res_row   = out_row_r;
  assign res_col   = out_col_r;
  assign res_last  = out_last_r && out_v_r;

endmodule
`default_nettype wire

>>> rtl/integer_matrix_multiply.sv
// Integer matrix multiply top level: size registers, front end, two-entry queue, back end.
// Depends on imm_pkg, imm_front, imm_fifo and imm_back.
// Throughput: one word per cycle while loading, unless the queue is full; a product then
//   runs rows_a*cols_b*inner_dim MACs, and busy rises only once the queue holds two words
//   of the next pair. The first result follows the final word of B, and any words queued
//   ahead, through the store read, product and output registers; the receiver cannot stall.
// Reset (synchronous, rst_n low) sets all sizes to 1 and empties the queue; stores keep data.
`default_nettype none
module integer_matrix_multiply #(
  parameter int MAX_DIM    = imm_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = imm_pkg::ELEM_WIDTH_DEF,
  localparam int IW        = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic signed [ELEM_WIDTH-1:0]       in_element_value,
  output logic                                    out_valid,
  output logic signed [ELEM_WIDTH-1:0]            out_product_value,
  output logic [IW-1:0]                           out_result_row,
  output logic [IW-1:0]                           out_result_col,
  output logic                                    out_last_result,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [imm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [imm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int QW    = $bits(imm_pkg::imm_tag_t) + AW + ELEM_WIDTH;

  logic [imm_pkg::CFG_DATA_W-1:0] rows_a_r, inner_dim_r, cols_b_r;
  logic [DW-1:0] rows_eff, inner_eff, cols_eff;

  logic                  accept;
  imm_pkg::imm_tag_t     f_tag, q_tag;
  logic [AW-1:0]         f_addr, q_addr;
  logic [ELEM_WIDTH-1:0] q_value;
  logic [QW-1:0]         q_wdata, q_rdata;
  logic                  q_pop;
  imm_pkg::imm_q_stat_t  q_stat;

  // Clamp a size register: zero reads as one, anything above MAX_DIM as MAX_DIM.
  function automatic logic [DW-1:0] clamp_dim(input logic [imm_pkg::CFG_DATA_W-1:0] v);
    if (v == '0) begin
      return DW'(1);
    end else if (int'(v) > MAX_DIM) begin
      return DW'(MAX_DIM);
    end else begin
      return DW'(v);
    end
  endfunction

  assign cfg_ready = 1'b1;
  assign rows_eff  = clamp_dim(rows_a_r);
  assign inner_eff = clamp_dim(inner_dim_r);
  assign cols_eff  = clamp_dim(cols_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= imm_pkg::CFG_DATA_W'(1);
      inner_dim_r <= imm_pkg::CFG_DATA_W'(1);
      cols_b_r    <= imm_pkg::CFG_DATA_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        imm_pkg::CFG_ROWS_A:    rows_a_r    <= cfg_data;
        imm_pkg::CFG_INNER_DIM: inner_dim_r <= cfg_data;
        imm_pkg::CFG_COLS_B:    cols_b_r    <= cfg_data;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Hold off new words only while the queue is full.
  assign busy   = q_stat.full;
  assign accept = start && !busy;

  imm_front #(
    .AW      (AW),
    .DW      (DW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .rows_eff  (rows_eff),
    .inner_eff (inner_eff),
    .cols_eff  (cols_eff),
    .tag       (f_tag),
    .addr      (f_addr)
  );

  assign q_wdata = {f_tag, f_addr, in_element_value};

  imm_fifo #(
    .W (QW)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  assign {q_tag, q_addr, q_value} = q_rdata;

  imm_back #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH),
    .AW         (AW),
    .IW         (IW),
    .DW         (DW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_stat.empty),
    .q_tag     (q_tag),
    .q_addr    (q_addr),
    .q_value   (q_value),
    .pop       (q_pop),
    .rows_eff  (rows_eff),
    .inner_eff (inner_eff),
    .cols_eff  (cols_eff),
    .res_valid (out_valid),
    .res_value (out_product_value),
    .res_row   (out_result_row),
    .res_col   (out_result_col),
    .res_last  (out_last_result)
  );

  // A finished product is never followed at once by another result word.
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result |=> !out_valid)
    else $error("result word right after final word of a product");

  // Result coordinates stay inside the configured result matrix.
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (DW'(out_result_row) < rows_eff))
    else $error("result row out of range");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (DW'(out_result_col) < cols_eff))
    else $error("result column out of range");

  // Last flag sits exactly on the bottom-right element.
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result |->
      (DW'(out_result_row) + DW'(1) == rows_eff) && (DW'(out_result_col) + DW'(1) == cols_eff))
    else $error("last flag on wrong element");

endmodule
`default_nettype wire
